/* src/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// No dependencies; the design files refer to it by scoped names, tb_top imports it.
package bba_pkg;

  // Default block count of the region.
  localparam int unsigned NumBlocksDefault = 256;

  // Region layout: bitmap header, then blocks on a 3 x 4 KiB stride.
  localparam logic [63:0] HdrBytes    = 64'h2000;
  localparam logic [63:0] BlkStride   = 64'h3000;
  localparam int unsigned StrideShift = 12;
  localparam logic [63:0] AllOnes     = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int unsigned WordBits = 64;
  localparam int unsigned AddrW    = 64;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgVirtBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPhysBase = 2'd1;

  typedef enum logic [0:0] {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SAllocRd,
    SAllocChk,
    SAllocAddr,
    SFreeDec,
    SFreeWr,
    SDone
  } ctrl_state_e;

endpackage

/* src/bba_channels.sv */
// Valid/ready channels of the allocator: request word in, response word out.
// Depends on bba_pkg for the op and status types.
interface bba_req_if;
  logic              valid;
  logic              ready;
  bba_pkg::op_e      op;
  logic [63:0]       free_addr;

  modport source (output valid, output op, output free_addr, input ready);
  modport sink   (input valid, input op, input free_addr, output ready);
endinterface

interface bba_rsp_if;
  logic              valid;
  logic              ready;
  bba_pkg::status_e  status;
  logic [63:0]       block_virt;
  logic [63:0]       block_phys;

  modport source (output valid, output status, output block_virt, output block_phys,
                  input ready);
  modport sink   (input valid, input status, input block_virt, input block_phys,
                  output ready);
endinterface

/* src/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_channels (interfaces), bba_ram and bba_fdec.
//
// Usage:
//   req channel carries one word per request: op (alloc or free) and free_addr.
//   rsp channel returns exactly one word per request: status, block_virt,
//   block_phys (addresses are zero unless an allocate succeeded).
//   cfg port writes region_virt_base (index 0) and region_phys_base (index 1);
//   write only while no request is in flight. Other indexes are dropped.
// Sequence (one request at a time, bitmap in a RAM with registered read):
//   allocate: reads word 0, then checks k bitmap words, one 64-bit word per cycle
//     (k = 1 .. NumBlocks/64 rounded up); StFull when all are used.
//   free: 4-stage address decoder, read, write back; a miss skips read and write.
//   The next request is taken in SIdle, in the cycle after the result moves to
//   the output register.
// Reset: the base registers go to zero and a clearing pass writes every
//   bitmap word to zero, one word per cycle; req.ready stays low meanwhile,
//   cfg writes are taken.
// Stall: the output register holds a finished word while rsp.ready is low;
//   one more request may be accepted and worked, then it waits in SDone.
module bitmap_block_allocator #(
  parameter int unsigned NumBlocks = bba_pkg::NumBlocksDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  bba_req_if.sink                      req,
  bba_rsp_if.source                    rsp
);

  localparam int unsigned Words   = (NumBlocks + 63) / 64;
  localparam int unsigned AW      = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned IW      = $clog2(NumBlocks);
  localparam int unsigned PW      = IW + 2;
  localparam int unsigned Rem     = NumBlocks % 64;
  localparam logic [AW-1:0] LastWord = AW'(Words - 1);
  // Bits past the last block in the last word read as used.
  localparam logic [63:0] LastPad = (Rem == 0) ? 64'd0 : (bba_pkg::AllOnes << Rem);

  bba_pkg::ctrl_state_e state_q, state_d;

  logic [AW-1:0]  clr_q, w_q;
  logic [IW-1:0]  idx_q;
  logic [63:0]    vbase_q, pbase_q;

  // pending result, then output register
  bba_pkg::status_e res_status_q;
  logic [63:0]      res_virt_q, res_phys_q;
  logic             out_valid_q;
  bba_pkg::status_e out_status_q;
  logic [63:0]      out_virt_q, out_phys_q;
  logic             can_out;

  // bitmap RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  // free decoder
  logic          fdec_start, fdec_done, fdec_hit;
  logic [IW-1:0] fdec_idx;

  // scan
  logic [63:0]   scan_word;
  logic          scan_found;
  logic [5:0]    scan_pos;
  logic          scan_last;
  logic [PW-1:0] blk_tri;
  logic [63:0]   blk_off;

  bba_ram #(
    .Width (64),
    .Depth (Words)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_fdec #(
    .NumBlocks (NumBlocks)
  ) u_fdec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fdec_start),
    .addr_i  (req.free_addr),
    .base_i  (vbase_q),
    .done_o  (fdec_done),
    .hit_o   (fdec_hit),
    .idx_o   (fdec_idx)
  );

  // Lowest clear bit of the word under scan.
  assign scan_last = (w_q == LastWord);
  assign scan_word = ram_rdata | (scan_last ? LastPad : 64'd0);
  assign scan_found = ~&scan_word;

  always_comb begin
    scan_pos = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!scan_word[i]) begin
        scan_pos = 6'(i);
      end
    end
  end

  // Block offset: header + idx * 0x3000 = header + (3 * idx) << 12.
  assign blk_tri = (PW'(idx_q) << 1) + PW'(idx_q);
  assign blk_off = bba_pkg::HdrBytes + (64'(blk_tri) << bba_pkg::StrideShift);

  assign can_out = !out_valid_q || rsp.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bba_pkg::SClear: begin
        if (clr_q == LastWord) begin
          state_d = bba_pkg::SIdle;
        end
      end
      bba_pkg::SIdle: begin
        if (req.valid) begin
          state_d = (req.op == bba_pkg::OpFree) ? bba_pkg::SFreeDec : bba_pkg::SAllocRd;
        end
      end
      bba_pkg::SAllocRd: state_d = bba_pkg::SAllocChk;
      bba_pkg::SAllocChk: begin
        if (scan_found) begin
          state_d = bba_pkg::SAllocAddr;
        end else if (scan_last) begin
          state_d = bba_pkg::SDone;
        end
      end
      bba_pkg::SAllocAddr: state_d = bba_pkg::SDone;
      bba_pkg::SFreeDec: begin
        if (fdec_done) begin
          state_d = fdec_hit ? bba_pkg::SFreeWr : bba_pkg::SDone;
        end
      end
      bba_pkg::SFreeWr: state_d = bba_pkg::SDone;
      bba_pkg::SDone: begin
        if (can_out) begin
          state_d = bba_pkg::SIdle;
        end
      end
      default: state_d = bba_pkg::SIdle;
    endcase
  end

  // Control outputs: RAM port, decoder start, request ready
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = w_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = w_q;
    fdec_start = 1'b0;
    req.ready  = 1'b0;
    case (state_q)
      bba_pkg::SClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      bba_pkg::SIdle: begin
        req.ready  = 1'b1;
        fdec_start = req.valid && (req.op == bba_pkg::OpFree);
      end
      bba_pkg::SAllocRd: begin
        ram_re = 1'b1;
      end
      bba_pkg::SAllocChk: begin
        if (scan_found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (64'd1 << scan_pos);
        end else if (!scan_last) begin
          // prefetch the next word; it is checked in the next cycle
          ram_re    = 1'b1;
          ram_raddr = w_q + AW'(1);
        end
      end
      bba_pkg::SFreeDec: begin
        if (fdec_done && fdec_hit) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(fdec_idx >> 6);
        end
      end
      bba_pkg::SFreeWr: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_q >> 6);
        ram_wdata = ram_rdata & (bba_pkg::AllOnes ^ (64'd1 << idx_q[5:0]));
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bba_pkg::SClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      vbase_q     <= '0;
      pbase_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == bba_pkg::SClear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == bba_pkg::SDone && can_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bba_pkg::CfgVirtBase: vbase_q <= cfg_data_i;
          bba_pkg::CfgPhysBase: pbase_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      bba_pkg::SIdle: begin
        w_q <= '0;
      end
      bba_pkg::SAllocChk: begin
        if (scan_found) begin
          idx_q <= IW'({w_q, scan_pos});
        end else begin
          w_q          <= w_q + AW'(1);
          res_status_q <= bba_pkg::StFull;
          res_virt_q   <= '0;
          res_phys_q   <= '0;
        end
      end
      bba_pkg::SAllocAddr: begin
        res_status_q <= bba_pkg::StOk;
        res_virt_q   <= vbase_q + blk_off;
        res_phys_q   <= pbase_q + blk_off;
      end
      bba_pkg::SFreeDec: begin
        idx_q        <= fdec_idx;
        res_status_q <= bba_pkg::StNotFound;
        res_virt_q   <= '0;
        res_phys_q   <= '0;
      end
      bba_pkg::SFreeWr: begin
        res_status_q <= bba_pkg::StOk;
      end
      bba_pkg::SDone: begin
        if (can_out) begin
          out_status_q <= res_status_q;
          out_virt_q   <= res_virt_q;
          out_phys_q   <= res_phys_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.status     = out_status_q;
  assign rsp.block_virt = out_virt_q;
  assign rsp.block_phys = out_phys_q;

  // The prefetch read never targets the word being written back.
  a_no_rw_same_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("bitmap read and write hit the same word");

  // An allocate write-back sets exactly one new bit.
  a_alloc_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::SAllocChk && ram_we) |-> ($countones(ram_wdata ^ ram_rdata) == 1))
    else $error("allocate changed other than one bit");

  // A free write-back changes at most one bit.
  a_free_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::SFreeWr) |-> ($countones(ram_wdata ^ ram_rdata) <= 1))
    else $error("free changed more than one bit");

  // The decoder only finishes while the controller waits for it.
  a_fdec_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdec_done |-> (state_q == bba_pkg::SFreeDec))
    else $error("free decoder result arrived outside its wait state");

  // Failed requests never report addresses (ok frees are not checked here).
  a_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.status != bba_pkg::StOk || $past(state_q) == bba_pkg::SFreeWr &&
      $rose(rsp.valid))) |-> (rsp.status != bba_pkg::StOk) ?
      (rsp.block_virt == '0 && rsp.block_phys == '0) : 1'b1)
    else $error("non-ok response carries an address");

endmodule

/* src/bba_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module bba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bba_fdec.sv */
// Free-address decoder: virtual address to block index, four pipeline stages.
// Depends on bba_pkg for the region layout constants.
module bba_fdec #(
  parameter int unsigned NumBlocks = bba_pkg::NumBlocksDefault,
  localparam int unsigned IW = $clog2(NumBlocks)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   addr_i,
  input  logic [63:0]   base_i,
  output logic          done_o,
  output logic          hit_o,
  output logic [IW-1:0] idx_o
);

  // q = rel >> 12 must be a multiple of 3 below 3 * NumBlocks.
  localparam int unsigned QW    = $clog2(3 * NumBlocks);
  localparam int unsigned Shift = QW + 1;
  localparam int unsigned PW    = IW + 2;
  localparam int unsigned HiW   = 64 - bba_pkg::StrideShift;
  localparam logic [Shift-1:0] Recip  = Shift'(((64'd1 << Shift) / 3) + 64'd1);
  localparam logic [HiW-1:0]   QLimit = HiW'(3 * NumBlocks);

  logic [3:0]          v_q, v_d;
  logic [63:0]         off1_q;
  logic [63:0]         rel;
  logic                ok2_q, ok3_q, hit4_q;
  logic [QW-1:0]       q2_q, q3_q;
  logic [QW+Shift-1:0] prod;
  logic [IW-1:0]       idx3_q, idx4_q;
  logic [PW-1:0]       tri3;

  assign v_d  = {v_q[2:0], start_i};
  assign rel  = off1_q - bba_pkg::HdrBytes;
  assign prod = (QW + Shift)'(q2_q) * (QW + Shift)'(Recip);
  assign tri3 = (PW'(idx3_q) << 1) + PW'(idx3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off1_q <= addr_i - base_i;
    ok2_q  <= (off1_q >= bba_pkg::HdrBytes) &&
              (rel[bba_pkg::StrideShift-1:0] == '0) &&
              (rel[63:bba_pkg::StrideShift] < QLimit);
    q2_q   <= rel[bba_pkg::StrideShift +: QW];
    // floor(q / 3) by reciprocal, exact for every q < 2^QW
    idx3_q <= prod[Shift +: IW];
    q3_q   <= q2_q;
    ok3_q  <= ok2_q;
    hit4_q <= ok3_q && (PW'(q3_q) == tri3);
    idx4_q <= idx3_q;
  end

  assign done_o = v_q[3];
  assign hit_o  = hit4_q;
  assign idx_o  = idx4_q;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the first-fit bitmap block allocator.
// Needs bba_pkg, the bba_req_if / bba_rsp_if channels and bitmap_block_allocator.
module tb_top;
  import bba_pkg::*;

  localparam int unsigned NBlocks  = NumBlocksDefault;
  localparam int unsigned MapWords = NBlocks / WordBits;
  localparam int unsigned DirRows  = 20;
  localparam int unsigned NumSets  = 5;
  localparam int unsigned HoldLen  = 80;
  // Indexes past the last register; writes there must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  // One response word as the allocator should return it.
  typedef struct packed {
    status_e     st;
    logic [63:0] virt;
    logic [63:0] phys;
  } grant_t;

  // Directed row: request plus, where obvious, the typed-in answer.
  typedef struct packed {
    op_e         op;
    logic [63:0] addr;
    logic        typed;
    grant_t      want;
  } stim_row_t;

  localparam grant_t NoGrant = '{StOk, 64'h0, 64'h0};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [63:0]         cfg_data_i;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the allocator: bitmap and both base registers.
  logic [63:0] used_map [MapWords];
  logic [63:0] virt_base_m;
  logic [63:0] phys_base_m;

  grant_t pending_grants [$];
  grant_t head_grant;
  int     bad_cnt = 0;

  // calm: no idling on either side; hold_asks/hold_seen: long rsp hold-offs
  bit calm = 1'b0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [63:0] set_virt [NumSets];
  logic [63:0] set_phys [NumSets];
  int          set_alloc_pct [NumSets] = '{60, 50, 30, 55, 45};

  // Directed rows, bases at zero right after reset. Block i sits at
  // 0x2000 + i*0x3000, so the typed-in addresses read straight off that.
  stim_row_t dir_rows [DirRows] = '{
    '{OpAlloc, 64'h0,                  1'b1, '{StOk,       64'h2000, 64'h2000}},
    '{OpAlloc, 64'h0,                  1'b1, '{StOk,       64'h5000, 64'h5000}},
    '{OpFree,  64'h0,                  1'b1, '{StNotFound, 64'h0,    64'h0}},    // header
    '{OpFree,  64'h1FFF,               1'b1, '{StNotFound, 64'h0,    64'h0}},    // header end
    '{OpFree,  64'h2001,               1'b1, '{StNotFound, 64'h0,    64'h0}},    // off stride
    '{OpFree,  64'h30_2000,            1'b1, '{StNotFound, 64'h0,    64'h0}},    // index 256
    '{OpFree,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NoGrant},
    '{OpFree,  64'h2000,               1'b1, '{StOk,       64'h0,    64'h0}},
    '{OpAlloc, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{StOk,       64'h2000, 64'h2000}},
    '{OpFree,  64'h2F_F000,            1'b1, '{StOk,       64'h0,    64'h0}},    // last, free
    '{OpFree,  64'h5000,               1'b1, '{StOk,       64'h0,    64'h0}},
    '{OpFree,  64'h5000,               1'b1, '{StOk,       64'h0,    64'h0}},    // twice
    '{OpAlloc, 64'h0,                  1'b1, '{StOk,       64'h5000, 64'h5000}},
    '{OpFree,  64'h4FFF,               1'b1, '{StNotFound, 64'h0,    64'h0}},
    '{OpFree,  64'h8000_0000_0000_0000, 1'b0, NoGrant},
    '{OpFree,  64'hC_2000,             1'b1, '{StOk,       64'h0,    64'h0}},    // block 64
    '{OpAlloc, 64'h0,                  1'b0, NoGrant},
    '{OpFree,  64'h5555_5555_5555_5555, 1'b0, NoGrant},
    '{OpFree,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NoGrant},
    '{OpAlloc, 64'h0,                  1'b0, NoGrant}
  };

  // First-fit step on the shadow: updates the bitmap, returns the answer.
  function automatic grant_t first_fit_step(input op_e op, input logic [63:0] addr);
    grant_t      g;
    logic [63:0] off;
    logic [63:0] rel;
    logic [63:0] blk;
    bit          found;
    g = '{StNotFound, 64'h0, 64'h0};
    found = 1'b0;
    if (op == OpAlloc) begin
      g.st = StFull;
      for (int i = 0; i < NBlocks; i++) begin
        if (!found && !used_map[i / WordBits][i % WordBits]) begin
          found = 1'b1;
          used_map[i / WordBits][i % WordBits] = 1'b1;
          off = HdrBytes + 64'(i) * BlkStride;
          g = '{StOk, virt_base_m + off, phys_base_m + off};
        end
      end
    end else begin
      off = addr - virt_base_m;            // wraps mod 2^64
      if (off >= HdrBytes) begin
        rel = off - HdrBytes;
        if (rel % BlkStride == 64'h0) begin
          blk = rel / BlkStride;
          if (blk < 64'(NBlocks)) begin
            used_map[blk / WordBits][blk % WordBits] = 1'b0;
            g.st = StOk;
          end
        end
      end
    end
    return g;
  endfunction

  // Offer one request word; on acceptance log what must come back.
  task automatic offer_word(input op_e op, input logic [63:0] addr, input bit typed,
                            input grant_t want);
    grant_t g;
    if (!calm) begin
      while ($urandom_range(99) < 21) begin
        req_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.free_addr <= addr;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    g = first_fit_step(op, addr);
    pending_grants.push_back(typed ? want : g);
  endtask

  // Back-to-back writes of both bases plus one dropped write.
  task automatic load_bases(input logic [63:0] v, input logic [63:0] p,
                            input logic [CfgIdxW-1:0] spare_idx);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgVirtBase;
    cfg_data_i <= v;
    @(posedge clk_i);
    virt_base_m = v;
    cfg_idx_i  <= CfgPhysBase;
    cfg_data_i <= p;
    @(posedge clk_i);
    phys_base_m = p;
    cfg_idx_i  <= spare_idx;
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Random mix. Frees mostly hit real blocks (biased low, where first fit
  // lands); the rest is header hits, off-stride, past-the-end and noise.
  task automatic run_mix(input int n, input int alloc_pct, input bit with_hold);
    logic [63:0] a;
    int          pick;
    int          idx;
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == n / 2) hold_asks++;
      if ($urandom_range(99) < alloc_pct) begin
        offer_word(OpAlloc, {$urandom, $urandom}, 1'b0, NoGrant);
      end else begin
        pick = $urandom_range(99);
        idx  = $urandom_range(1) ? $urandom_range(31) : $urandom_range(NBlocks - 1);
        a    = virt_base_m + HdrBytes + 64'(idx) * BlkStride;
        if (pick < 8) begin
          a = {$urandom, $urandom};
        end else if (pick < 14) begin
          a = virt_base_m + 64'($urandom_range(16'h1FFF));
        end else if (pick < 22) begin
          a = a + 64'($urandom_range(16'h2FFF, 1));
        end else if (pick < 30) begin
          a = virt_base_m + HdrBytes + 64'(NBlocks + $urandom_range(2000)) * BlkStride;
        end
        offer_word(OpFree, a, 1'b0, NoGrant);
      end
    end
  endtask

  // Receiver: random back-pressure, plus a long counted hold on request.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen++;
        hold_left = HoldLen - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  // Response checker: in-order compare against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_grants.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10)
          $display("unexpected word: status %0d virt %h phys %h",
                   rsp_ch.status, rsp_ch.block_virt, rsp_ch.block_phys);
      end else begin
        head_grant = pending_grants.pop_front();
        if (rsp_ch.status !== head_grant.st || rsp_ch.block_virt !== head_grant.virt ||
            rsp_ch.block_phys !== head_grant.phys) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("mismatch: exp status %0d virt %h phys %h, got status %0d virt %h phys %h",
                     head_grant.st, head_grant.virt, head_grant.phys,
                     rsp_ch.status, rsp_ch.block_virt, rsp_ch.block_phys);
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CfgVirtBase;
    cfg_data_i       = 64'h0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OpAlloc;
    req_ch.free_addr = 64'h0;
    virt_base_m      = 64'h0;
    phys_base_m      = 64'h0;
    for (int w = 0; w < MapWords; w++) used_map[w] = 64'h0;

    // Base settings: both extremes high, a header that wraps past zero,
    // random values, and zero written explicitly.
    set_virt[0] = AllOnes;                set_phys[0] = AllOnes;
    set_virt[1] = 64'hFFFF_FFFF_FFFF_F000; set_phys[1] = 64'h0;
    set_virt[2] = {$urandom, $urandom};   set_phys[2] = {$urandom, $urandom};
    set_virt[3] = 64'h0;                  set_phys[3] = 64'h0;
    set_virt[4] = {$urandom, $urandom};   set_phys[4] = {$urandom, $urandom};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset bases; ready stays low through the clearing pass.
    for (int r = 0; r < DirRows; r++)
      offer_word(dir_rows[r].op, dir_rows[r].addr, dir_rows[r].typed, dir_rows[r].want);

    for (int s = 0; s < NumSets; s++) begin
      // Sender pause: bases only change with nothing in flight.
      req_ch.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clk_i);
      load_bases(set_virt[s], set_phys[s], (s % 2 == 0) ? CfgIdxSpareLo : CfgIdxSpareHi);
      if (s == 2) begin
        // Fill the whole map with no idling, then keep asking while full.
        calm = 1'b1;
        for (int k = 0; k < NBlocks + 10; k++)
          offer_word(OpAlloc, {$urandom, $urandom}, 1'b0, NoGrant);
        calm = 1'b0;
      end
      run_mix(84, set_alloc_pct[s], s == 1 || s == 4);
    end

    req_ch.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("bitmap_block_allocator test passed");
    end else begin
      $display("bitmap_block_allocator test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("bitmap_block_allocator test failed");
    $finish;
  end

endmodule

/* filelist.f */
src/bba_pkg.sv
src/bba_channels.sv
src/bba_ram.sv
src/bba_fdec.sv
src/bitmap_block_allocator.sv
sim/tb_top.sv
